/* hdl/cartesian_to_spherical_assert.svh */
// ----------------------------------------------------------------------------
// Cartesian to spherical assertion macros
// Concurrent check helpers shared by the converter top level.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define C2S_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("c2s check failed");

// next-cycle implication, checked outside reset
`define C2S_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("c2s check failed");

`endif

/* hdl/c2s_pkg.sv */
// ----------------------------------------------------------------------------
// c2s_pkg
// Types, formats and CORDIC constants of the cartesian to spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 24;
    localparam int MAX_STAGES  = 24;
    // datapath width: coordinate, fraction, plus headroom for CORDIC growth
    localparam int DW          = COORD_WIDTH + FRAC_BITS + 3;
    localparam int ANG_W       = 32;

    localparam logic [31:0] GAIN_Q32      = 32'd2608131496;
    localparam logic [31:0] GAIN_TAIL_Q32 = 32'd1738754331;
    localparam logic [31:0] ANG_HALF      = 32'h8000_0000;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_AZ_UNDEF = 2'd1;
    localparam logic [1:0] ST_ORIGIN   = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic signed [COORD_WIDTH-1:0] z_coord;
    } t_in;

    typedef struct packed {
        logic        [15:0] radius;
        logic        [15:0] azimuth;
        logic signed [15:0] elevation;
        logic        [1:0]  status;
    } t_out;

    // vector under rotation and its accumulated angle
    typedef struct packed {
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic [ANG_W-1:0]     ang;
    } t_vec;

    // data riding along the pipe
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] y;
        logic [ANG_W-1:0]              ang1;
        logic [ANG_W-1:0]              ang2;
        logic [1:0]                    status;
    } t_side;

    // atan(2^-i) in turns, Q32
    function automatic logic [31:0] atan_q32(input int idx);
        logic [31:0] r;
        case (idx)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2FA;
            15:      r = 32'h0000517D;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A30;
            19:      r = 32'h00000518;
            20:      r = 32'h0000028C;
            21:      r = 32'h00000146;
            22:      r = 32'h000000A3;
            23:      r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

/* hdl/c2s_prep.sv */
// ----------------------------------------------------------------------------
// c2s_prep
// Entry stage: scales the point, folds the left half plane, sets status.
// ----------------------------------------------------------------------------
module c2s_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_valid,
    input  c2s_pkg::t_in   i_pt,
    output logic           o_valid,
    output c2s_pkg::t_vec  o_vec,
    output c2s_pkg::t_side o_side
);

    localparam int EXT = c2s_pkg::DW - c2s_pkg::COORD_WIDTH;

    logic                          r_valid;
    c2s_pkg::t_vec                 r_vec;
    c2s_pkg::t_side                r_side;
    c2s_pkg::t_vec                 n_vec;
    c2s_pkg::t_side                n_side;
    logic signed [c2s_pkg::DW-1:0] xs;
    logic signed [c2s_pkg::DW-1:0] zs;

    always_comb begin
        xs = {{EXT{i_pt.x_coord[c2s_pkg::COORD_WIDTH-1]}}, i_pt.x_coord} <<< c2s_pkg::FRAC_BITS;
        zs = {{EXT{i_pt.z_coord[c2s_pkg::COORD_WIDTH-1]}}, i_pt.z_coord} <<< c2s_pkg::FRAC_BITS;
        // left half plane: rotate by a half turn so the CORDIC converges
        if (i_pt.x_coord[c2s_pkg::COORD_WIDTH-1]) begin
            n_vec.a   = -xs;
            n_vec.b   = -zs;
            n_vec.ang = c2s_pkg::ANG_HALF;
        end else begin
            n_vec.a   = xs;
            n_vec.b   = zs;
            n_vec.ang = '0;
        end
        n_side.y    = i_pt.y_coord;
        n_side.ang1 = '0;
        n_side.ang2 = '0;
        if (i_pt.x_coord == '0 && i_pt.z_coord == '0) begin
            n_side.status = (i_pt.y_coord == '0) ? c2s_pkg::ST_ORIGIN : c2s_pkg::ST_AZ_UNDEF;
        end else begin
            n_side.status = c2s_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vec  <= n_vec;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

/* hdl/c2s_cell.sv */
// ----------------------------------------------------------------------------
// c2s_cell
// One CORDIC vectoring micro-rotation, registered, fixed shift per cell.
// ----------------------------------------------------------------------------
module c2s_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_valid,
    input  c2s_pkg::t_vec  i_vec,
    input  c2s_pkg::t_side i_side,
    output logic           o_valid,
    output c2s_pkg::t_vec  o_vec,
    output c2s_pkg::t_side o_side
);

    localparam logic [31:0] ATAN = c2s_pkg::atan_q32(STAGE);

    logic                          r_valid;
    c2s_pkg::t_vec                 r_vec;
    c2s_pkg::t_side                r_side;
    c2s_pkg::t_vec                 n_vec;
    logic signed [c2s_pkg::DW-1:0] a;
    logic signed [c2s_pkg::DW-1:0] b;
    logic signed [c2s_pkg::DW-1:0] da;
    logic signed [c2s_pkg::DW-1:0] db;

    always_comb begin
        a  = i_vec.a;
        b  = i_vec.b;
        da = b >>> STAGE;   // floor shift
        db = a >>> STAGE;
        // steer b toward zero
        if (!b[c2s_pkg::DW-1]) begin
            n_vec.a   = a + da;
            n_vec.b   = b - db;
            n_vec.ang = i_vec.ang + ATAN;
        end else begin
            n_vec.a   = a - da;
            n_vec.b   = b + db;
            n_vec.ang = i_vec.ang - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vec  <= n_vec;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

/* hdl/c2s_gain.sv */
// ----------------------------------------------------------------------------
// c2s_gain
// CORDIC gain compensation: multiply by K in Q32, truncated, two stages.
// ----------------------------------------------------------------------------
module c2s_gain #(
    parameter int STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_load,
    input  logic                          i_valid,
    input  logic signed [c2s_pkg::DW-1:0] i_val,
    input  c2s_pkg::t_side                i_side,
    output logic [1:0]                    o_valid,
    output logic signed [c2s_pkg::DW-1:0] o_val,
    output c2s_pkg::t_side                o_side
);

    localparam longint unsigned K64 = 64'(c2s_pkg::GAIN_Q32)
                                    + (64'(c2s_pkg::GAIN_TAIL_Q32) >> (2 * STAGES));
    localparam logic [31:0] K    = 32'(K64);
    localparam int          HI_W = c2s_pkg::DW - 33;

    logic                          r_v1;
    logic                          r_v2;
    logic [HI_W+31:0]              r_phi;
    logic [63:0]                   r_plo;
    c2s_pkg::t_side                r_side1;
    logic signed [c2s_pkg::DW-1:0] r_val;
    c2s_pkg::t_side                r_side2;
    logic                          pos;
    logic [HI_W-1:0]               hi;
    logic [31:0]                   lo;

    // non-positive values compensate to zero
    always_comb begin
        pos = !i_val[c2s_pkg::DW-1] && (i_val != '0);
        hi  = pos ? i_val[c2s_pkg::DW-2:32] : '0;
        lo  = pos ? i_val[31:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_load[0]) begin
                r_v1 <= i_valid;
            end
            if (i_load[1]) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_phi   <= {32'd0, hi} * {{HI_W{1'b0}}, K};
            r_plo   <= {32'd0, lo} * {32'd0, K};
            r_side1 <= i_side;
        end
        if (i_load[1]) begin
            r_val   <= $signed(c2s_pkg::DW'(r_phi) + c2s_pkg::DW'(r_plo[63:32]));
            r_side2 <= r_side1;
        end
    end

    assign o_valid = {r_v2, r_v1};
    assign o_val   = r_val;
    assign o_side  = r_side2;

endmodule

/* hdl/cartesian_to_spherical.sv */
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Point (x, y, z) to radius, azimuth and elevation by two CORDIC passes.
// ----------------------------------------------------------------------------
// Input channel i_valid / o_ready / i_data carries one signed point per
// transaction; output channel o_valid / i_ready / o_data returns radius,
// azimuth (65536 per turn), elevation and status for each point, in order.
// The datapath is a row of registered cells: entry stage, CORDIC_STAGES
// rotation cells on (x, z), two gain stages, CORDIC_STAGES rotation cells on
// (horizontal radius, y), two gain stages and the output register, with
// CORDIC_STAGES capped at c2s_pkg::MAX_STAGES. Throughput is one point per
// cycle while i_ready is high or a cell of the row is free.
// A stall on the output holds only the cells that are occupied; empty
// cells keep filling, so o_ready stays high while any cell of the row is
// free.
// Status 1 flags x = z = 0 with y nonzero (azimuth forced to 0); status 2
// flags the origin (all results 0).
// Synchronous reset clears every cell's valid flag; the payload registers
// are not reset. No transaction is pending after reset.
// ----------------------------------------------------------------------------
`include "cartesian_to_spherical_assert.svh"

module cartesian_to_spherical #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  c2s_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output c2s_pkg::t_out o_data
);

    localparam int NS  = (CORDIC_STAGES > c2s_pkg::MAX_STAGES) ? c2s_pkg::MAX_STAGES
                                                                : CORDIC_STAGES;
    localparam int L   = 2 * NS + 6;
    localparam int EXT = c2s_pkg::DW - c2s_pkg::COORD_WIDTH;
    localparam int RW  = c2s_pkg::DW + 1 - c2s_pkg::FRAC_BITS;

    logic [L-1:0] v;
    logic [L-1:0] ld;

    c2s_pkg::t_vec  p1_vec  [0:NS];
    c2s_pkg::t_side p1_side [0:NS];
    c2s_pkg::t_vec  p2_vec  [0:NS];
    c2s_pkg::t_side p2_side [0:NS];

    c2s_pkg::t_side                g1_side_in;
    logic signed [c2s_pkg::DW-1:0] g1_val;
    c2s_pkg::t_side                g2_side_in;
    logic signed [c2s_pkg::DW-1:0] g2_val;
    c2s_pkg::t_side                g2_side;

    logic                          r_o_valid;
    c2s_pkg::t_out                 r_o_data;
    c2s_pkg::t_out                 n_o_data;
    logic [c2s_pkg::DW:0]          rsum;
    logic [RW-1:0]                 rad;
    logic signed [32:0]            esum;
    logic signed [16:0]            elev;

    // a cell loads when the receiver is ready or when it or any cell downstream of it is free
    genvar k;
    generate
        for (k = 0; k < L; k++) begin : g_ld
            assign ld[k] = i_ready | ~(&v[L-1:k]);
        end
    endgenerate

    assign o_ready = ld[0];

    c2s_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld[0]),
        .i_valid (i_valid),
        .i_pt    (i_data),
        .o_valid (v[0]),
        .o_vec   (p1_vec[0]),
        .o_side  (p1_side[0])
    );

    generate
        for (k = 0; k < NS; k++) begin : g_pass1
            c2s_cell #(
                .STAGE (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (ld[k+1]),
                .i_valid (v[k]),
                .i_vec   (p1_vec[k]),
                .i_side  (p1_side[k]),
                .o_valid (v[k+1]),
                .o_vec   (p1_vec[k+1]),
                .o_side  (p1_side[k+1])
            );
        end
    endgenerate

    always_comb begin
        g1_side_in      = p1_side[NS];
        g1_side_in.ang1 = p1_vec[NS].ang;
    end

    c2s_gain #(
        .STAGES (NS)
    ) u_gain1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld[NS+2:NS+1]),
        .i_valid (v[NS]),
        .i_val   (p1_vec[NS].a),
        .i_side  (g1_side_in),
        .o_valid (v[NS+2:NS+1]),
        .o_val   (g1_val),
        .o_side  (p2_side[0])
    );

    // second pass rotates (horizontal radius, y)
    always_comb begin
        p2_vec[0].a   = g1_val;
        p2_vec[0].b   = {{EXT{p2_side[0].y[c2s_pkg::COORD_WIDTH-1]}}, p2_side[0].y}
                        <<< c2s_pkg::FRAC_BITS;
        p2_vec[0].ang = '0;
    end

    generate
        for (k = 0; k < NS; k++) begin : g_pass2
            c2s_cell #(
                .STAGE (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (ld[NS+3+k]),
                .i_valid (v[NS+2+k]),
                .i_vec   (p2_vec[k]),
                .i_side  (p2_side[k]),
                .o_valid (v[NS+3+k]),
                .o_vec   (p2_vec[k+1]),
                .o_side  (p2_side[k+1])
            );
        end
    endgenerate

    always_comb begin
        g2_side_in      = p2_side[NS];
        g2_side_in.ang2 = p2_vec[NS].ang;
    end

    c2s_gain #(
        .STAGES (NS)
    ) u_gain2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld[2*NS+4:2*NS+3]),
        .i_valid (v[2*NS+2]),
        .i_val   (p2_vec[NS].a),
        .i_side  (g2_side_in),
        .o_valid (v[2*NS+4:2*NS+3]),
        .o_val   (g2_val),
        .o_side  (g2_side)
    );

    // output formatting: rounding, saturation, clamping, special cases
    always_comb begin
        rsum = {1'b0, g2_val} + ((c2s_pkg::DW + 1)'(1) << (c2s_pkg::FRAC_BITS - 1));
        rad  = rsum[c2s_pkg::DW:c2s_pkg::FRAC_BITS];
        n_o_data.radius  = (rad > RW'(16'hFFFF)) ? 16'hFFFF : rad[15:0];

        n_o_data.azimuth = 16'((g2_side.ang1 + 32'h0000_8000) >> 16);

        esum = $signed({g2_side.ang2[31], g2_side.ang2}) + 33'sd32768;
        elev = esum[32:16];
        if (elev > 17'sd16384) begin
            n_o_data.elevation = 16'sd16384;
        end else if (elev < -17'sd16384) begin
            n_o_data.elevation = -16'sd16384;
        end else begin
            n_o_data.elevation = elev[15:0];
        end

        n_o_data.status = g2_side.status;
        if (g2_side.status != c2s_pkg::ST_OK) begin
            n_o_data.azimuth = '0;
        end
        if (g2_side.status == c2s_pkg::ST_ORIGIN) begin
            n_o_data.radius    = '0;
            n_o_data.elevation = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ld[L-1]) begin
            r_o_valid <= v[L-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[L-1]) begin
            r_o_data <= n_o_data;
        end
    end

    assign v[L-1]  = r_o_valid;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    `C2S_ASSERT_NOW(a_free_cell_ready, !(&v), o_ready)
    `C2S_ASSERT_NOW(a_origin_zero, o_valid && o_data.status == c2s_pkg::ST_ORIGIN, o_data.radius == 16'd0 && o_data.azimuth == 16'd0 && o_data.elevation == 16'sd0)
    `C2S_ASSERT_NOW(a_undef_az_zero, o_valid && o_data.status == c2s_pkg::ST_AZ_UNDEF, o_data.azimuth == 16'd0)
    `C2S_ASSERT_NOW(a_elev_range, o_valid, o_data.elevation <= 16'sd16384 && o_data.elevation >= -16'sd16384)
    `C2S_ASSERT_NEXT(a_accept_enters, i_valid && o_ready, v[0])

endmodule

/* tb/sv/cartesian_to_spherical_test.sv */
// ----------------------------------------------------------------------------
// cartesian_to_spherical_test
// Self-checking bench for the point to radius/azimuth/elevation converter.
// ----------------------------------------------------------------------------
// Points go in on the valid/ready input channel, one per transaction. Each
// accepted point is run through a bit-exact CORDIC predictor and the
// prediction is queued. Every result transaction is checked field by field
// against the oldest queued prediction. The tests cover the special statuses,
// the axes and the corners of the input range, a long output stall that
// backs up the pipe, and random points with random idling on both sides.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_test;

    localparam int STAGES        = 16;
    localparam int PIPE_LATENCY  = 2 * STAGES + 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BLOCKS = 15;
    localparam int BLOCK_ITEMS   = 100;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    c2s_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    c2s_pkg::t_out o_data;

    cartesian_to_spherical #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    // rotation state: vector and accumulated angle
    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [31:0]        ang;
    } t_rot_state;

    // atan(2^-i) in turns, Q32
    logic [31:0] atan_turns [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    c2s_pkg::t_out pending_results[$];
    int            fail_count;
    int unsigned   cycle_count;
    bit            tx_idle;
    bit            rx_idle;
    int            rx_long_hold;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int applied_stages();
        return (STAGES > 24) ? 24 : STAGES;
    endfunction

    // drive b to zero, accumulate the angle of (a, b)
    function automatic t_rot_state vector_to_axis(longint a_in, longint b_in,
                                                  logic [31:0] ang_in);
        longint      a, b, da, db;
        logic [31:0] ang;
        t_rot_state  r;
        a   = a_in;
        b   = b_in;
        ang = ang_in;
        for (int i = 0; i < applied_stages(); i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a   = a + da;
                b   = b - db;
                ang = ang + atan_turns[i];
            end else begin
                a   = a - da;
                b   = b + db;
                ang = ang - atan_turns[i];
            end
        end
        r.a   = a;
        r.b   = b;
        r.ang = ang;
        return r;
    endfunction

    // multiply by the CORDIC gain in Q32, truncated
    function automatic longint unsigned gain_scaled(longint v);
        longint unsigned u, k, hi, lo;
        if (v <= 0)
            return 0;
        u  = v;
        k  = 64'(c2s_pkg::GAIN_Q32)
           + (64'(c2s_pkg::GAIN_TAIL_Q32) >> (2 * applied_stages()));
        hi = u >> 32;
        lo = u & 64'hFFFF_FFFF;
        return hi * k + ((lo * k) >> 32);
    endfunction

    function automatic c2s_pkg::t_out spherical_of(c2s_pkg::t_in p);
        longint          x, y, z, a, b, e;
        longint unsigned rad;
        logic [31:0]     az_ang, az_round;
        t_rot_state      v;
        c2s_pkg::t_out   r;
        x = longint'(p.x_coord);
        y = longint'(p.y_coord);
        z = longint'(p.z_coord);
        a = x <<< c2s_pkg::FRAC_BITS;
        b = z <<< c2s_pkg::FRAC_BITS;
        az_ang = 32'd0;
        // left half plane: rotate by half a turn first
        if (a < 0) begin
            a      = -a;
            b      = -b;
            az_ang = c2s_pkg::ANG_HALF;
        end
        v      = vector_to_axis(a, b, az_ang);
        az_ang = v.ang;
        v      = vector_to_axis(longint'(gain_scaled(v.a)), y <<< c2s_pkg::FRAC_BITS,
                                32'd0);

        rad = (gain_scaled(v.a) + (64'd1 << (c2s_pkg::FRAC_BITS - 1)))
              >> c2s_pkg::FRAC_BITS;
        if (rad > 65535)
            rad = 65535;
        az_round = az_ang + 32'h8000;
        e = longint'($signed(v.ang));
        e = (e + 64'sd32768) >>> 16;
        if (e > 16384)
            e = 16384;
        if (e < -16384)
            e = -16384;

        r.radius    = rad[15:0];
        r.azimuth   = az_round[31:16];
        r.elevation = e[15:0];
        r.status    = c2s_pkg::ST_OK;
        if (x == 0 && z == 0) begin
            r.azimuth = '0;
            r.status  = (y == 0) ? c2s_pkg::ST_ORIGIN : c2s_pkg::ST_AZ_UNDEF;
        end
        if (r.status == c2s_pkg::ST_ORIGIN) begin
            r.radius    = '0;
            r.elevation = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock, cycle count, watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: ready with random stalls, plus a long hold on request
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_long_hold != 0) begin
                stall        = rx_long_hold;
                rx_long_hold = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (stall != 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready) && rx_long_hold == 0);
        end
    end

    function automatic void note_field(string label, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        c2s_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, o_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                note_field("radius", want.radius, o_data.radius);
                note_field("azimuth", want.azimuth, o_data.azimuth);
                note_field("elevation", want.elevation, o_data.elevation);
                note_field("status", want.status, o_data.status);
            end
        end
    end

    // ------------------------------------------------------------------------
    // point side
    // ------------------------------------------------------------------------
    function automatic c2s_pkg::t_in pt(int x, int y, int z);
        c2s_pkg::t_in p;
        p.x_coord = x[15:0];
        p.y_coord = y[15:0];
        p.z_coord = z[15:0];
        return p;
    endfunction

    function automatic logic [15:0] corner_value();
        logic [15:0] corners [7] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
                                     16'h0001, 16'h7FFE, 16'h7FFF};
        return corners[3'($urandom_range(0, 6))];
    endfunction

    function automatic c2s_pkg::t_in random_point();
        c2s_pkg::t_in p;
        int           kind;
        kind = $urandom_range(0, 9);
        p = pt($urandom, $urandom, $urandom);
        case (kind)
            6: begin
                // near the origin, where rounding is tight
                p.x_coord = 16'(int'($urandom_range(0, 40)) - 20);
                p.y_coord = 16'(int'($urandom_range(0, 40)) - 20);
                p.z_coord = 16'(int'($urandom_range(0, 40)) - 20);
            end
            7: begin
                p.x_coord = '0;
                p.z_coord = '0;
                if ($urandom_range(0, 7) == 0)
                    p.y_coord = '0;
            end
            8: begin
                if ($urandom_range(0, 1))
                    p.x_coord = '0;
                else
                    p.z_coord = '0;
            end
            9: begin
                p.x_coord = corner_value();
                p.y_coord = corner_value();
                p.z_coord = corner_value();
            end
            default: ;
        endcase
        return p;
    endfunction

    // offer one point and queue its prediction once it is taken
    task automatic send_point(input c2s_pkg::t_in p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= p;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(spherical_of(p));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_special_cases();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_point(pt(0, 0, 0));
        send_point(pt(0, 32767, 0));
        send_point(pt(0, -32768, 0));
        send_point(pt(0, 1, 0));
        send_point(pt(0, -1, 0));
        end_burst();
    endtask

    task automatic test_axes_and_extremes();
        send_point(pt(32767, 0, 0));
        send_point(pt(-32768, 0, 0));
        send_point(pt(0, 0, 32767));
        send_point(pt(0, 0, -32768));
        send_point(pt(1, 0, 0));
        send_point(pt(-1, 0, 0));
        send_point(pt(0, 0, 1));
        send_point(pt(0, 0, -1));
        send_point(pt(32767, 32767, 32767));
        send_point(pt(-32768, -32768, -32768));
        send_point(pt(32767, -32768, -32768));
        send_point(pt(-32768, 32767, 32767));
        send_point(pt(1000, 0, 1000));
        send_point(pt(-1, -1, -1));
        send_point(pt(1, 32767, 0));
        send_point(pt(-1, -32768, 0));
        end_burst();
    endtask

    // hold the output while points keep coming so the pipe fills
    task automatic test_output_stall();
        tx_idle      = 1'b0;
        rx_long_hold = 300;
        for (int i = 0; i < 120; i++)
            send_point(random_point());
        end_burst();
    endtask

    task automatic test_random_points();
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            // cycle through idling on both, sender only, receiver only, none
            tx_idle = (blk % 4 == 0) || (blk % 4 == 1);
            rx_idle = (blk % 4 == 0) || (blk % 4 == 2);
            for (int i = 0; i < BLOCK_ITEMS; i++)
                send_point(random_point());
        end
        end_burst();
    endtask

    initial begin
        fail_count   = 0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        rx_long_hold = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_axes_and_extremes();
        test_output_stall();
        test_random_points();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
